// ===== rtl/lebh_pkg.sv =====
// types and constants shared by the link event and burst histogram statistics block
`timescale 1ns / 1ps
`default_nettype none
package lebh_pkg;

	localparam int DATA_W  = 64;
	localparam int PADDR_W = 3;

	// counter memory layout
	localparam int CNT_DEPTH = 9;
	localparam int CNT_AW    = 4;

	localparam logic [CNT_AW-1:0] CNT_ATT     = 4'd0;
	localparam logic [CNT_AW-1:0] CNT_OK      = 4'd1;
	localparam logic [CNT_AW-1:0] CNT_FAIL    = 4'd2;
	localparam logic [CNT_AW-1:0] CNT_TMH     = 4'd3;
	localparam logic [CNT_AW-1:0] CNT_TIMEOUT = 4'd4;
	localparam logic [CNT_AW-1:0] CNT_RX      = 4'd5;
	localparam logic [CNT_AW-1:0] CNT_CRC     = 4'd6;
	localparam logic [CNT_AW-1:0] CNT_REC     = 4'd7;
	localparam logic [CNT_AW-1:0] CNT_PKTF    = 4'd8;

	// statistic ids on the result channel
	localparam logic [3:0] STAT_ATT     = 4'd0;
	localparam logic [3:0] STAT_LOST    = 4'd7;
	localparam logic [3:0] STAT_INJ     = 4'd8;
	localparam logic [3:0] STAT_EVENTS  = 4'd11;
	localparam logic [3:0] STAT_LONGEST = 4'd12;
	localparam logic [3:0] STAT_BUCKET  = 4'd13;

	// register addresses
	localparam logic [PADDR_W-1:0] ADDR_INJECTED = 3'd0;

	typedef enum logic [3:0] {
		CMD_BLK_OK   = 4'd0,
		CMD_BLK_FAIL = 4'd1,
		CMD_TMH      = 4'd2,
		CMD_TIMEOUT  = 4'd3,
		CMD_RX       = 4'd4,
		CMD_CRC      = 4'd5,
		CMD_REC      = 4'd6,
		CMD_PKTF     = 4'd7,
		CMD_HOLES    = 4'd8,
		CMD_FINAL    = 4'd9,
		CMD_SNAP     = 4'd10,
		CMD_BKT      = 4'd11
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CNT1,
		ST_CNT2,
		ST_HIST,
		ST_SNAP_RD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [3:0]  command;
		logic [15:0] hole_total;
		logic [8:0]  bucket_number;
	} in_item_t;

	typedef struct packed {
		logic [3:0]        stat_id;
		logic [DATA_W-1:0] stat_value;
		logic              last_of_run;
	} out_item_t;

endpackage
`default_nettype wire

// ===== rtl/lebh_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module lebh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/link_event_and_burst_histogram_stats_top.sv =====
// Link event counters and burst-length histogram, with snapshot and bucket reads.
// Counter events read the counter ram and write the count back (block ok and fail then do
// the same for the attempted count); a nonzero hole count is registered directly, and a
// burst close reads and writes back its histogram bucket. A snapshot reads the statistics
// in turn, 13 results in all, each held while the output stalls; a bucket read gives one.
// After reset a clearing pass over max(MAX_BURST, 9) addresses zeroes both rams; no item
// is accepted during it, register writes are.
`timescale 1ns / 1ps
`default_nettype none
module link_event_and_burst_histogram_stats_top
	import lebh_pkg::*;
#(
	parameter int MAX_BURST = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// item input
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire in_item_t           in_item,
	// result output
	output logic                    out_valid,
	input  wire logic               out_stall,
	output out_item_t               out_item,
	// register port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic      [DATA_W-1:0]  prdata,
	output logic                    pready
);

	localparam int HW    = $clog2(MAX_BURST);
	localparam int LW    = $clog2(MAX_BURST + 1);
	localparam int SW    = ((LW > 16) ? LW : 16) + 1;
	localparam int BW    = (HW > 9) ? HW : 9;
	localparam int CLR_N = (MAX_BURST > CNT_DEPTH) ? MAX_BURST : CNT_DEPTH;
	localparam int CLR_W = $clog2(CLR_N);

	state_t state_q, state_d;

	logic [CLR_W-1:0]  clr_q;
	logic [DATA_W-1:0] injected_q;
	logic [LW-1:0]     open_len_q;
	logic [DATA_W-1:0] closed_events_q;
	logic [DATA_W-1:0] closed_lost_q;
	logic [LW-1:0]     longest_q;

	logic [CNT_AW-1:0] cnt_addr_q;
	logic [HW-1:0]     hist_addr_q;
	logic              two_q;
	logic              bkt_ok_q;
	logic [3:0]        id_q;

	logic      out_valid_q;
	out_item_t out_item_q;

	// ram ports
	logic              cnt_we, cnt_re, hist_we, hist_re;
	logic [CNT_AW-1:0] cnt_waddr, cnt_raddr;
	logic [HW-1:0]     hist_waddr, hist_raddr;
	logic [DATA_W-1:0] cnt_wdata, cnt_rdata, hist_wdata, hist_rdata;

	cmd_t              cmd;
	logic              in_take;
	logic              out_free;
	logic              out_load;
	logic              close_req;
	logic              bkt_ok;
	logic [LW-1:0]     open_m1;
	logic [BW-1:0]     bkt_m1;
	logic [SW-1:0]     hole_sum;
	logic [LW-1:0]     hole_sat;
	logic              clr_last, clr_in_cnt, clr_in_hist;
	logic              id_is_cnt, id_last;
	logic [CNT_AW-1:0] id_cnt_addr;
	logic [DATA_W-1:0] snap_events, snap_lost, emit_value;
	logic [LW-1:0]     snap_longest;

	assign cmd      = cmd_t'(in_item.command);
	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;

	assign close_req = ((cmd == CMD_HOLES) && (in_item.hole_total == 16'd0)) ||
		(cmd == CMD_FINAL);
	assign bkt_ok    = (in_item.bucket_number != 9'd0) &&
		(int'(in_item.bucket_number) <= MAX_BURST);
	assign open_m1   = open_len_q - LW'(1);
	assign bkt_m1    = BW'(in_item.bucket_number) - BW'(1);
	assign hole_sum  = SW'(open_len_q) + SW'(in_item.hole_total);
	assign hole_sat  = (hole_sum > SW'(MAX_BURST)) ? LW'(MAX_BURST) : hole_sum[LW-1:0];

	assign clr_last    = (int'(clr_q) == CLR_N - 1);
	assign clr_in_cnt  = (int'(clr_q) < CNT_DEPTH);
	assign clr_in_hist = (int'(clr_q) < MAX_BURST);

	// statistics 0..6 and 9..10 live in the counter ram
	assign id_is_cnt   = (id_q < STAT_LOST) || ((id_q > STAT_INJ) && (id_q < STAT_EVENTS));
	assign id_cnt_addr = (id_q < STAT_LOST) ? id_q : id_q - 4'd2;
	assign id_last     = (id_q == STAT_LONGEST) || (id_q == STAT_BUCKET);

	// open burst counts in a snapshot
	assign snap_events  = closed_events_q + DATA_W'(open_len_q != '0);
	assign snap_lost    = closed_lost_q + DATA_W'(open_len_q);
	assign snap_longest = (open_len_q > longest_q) ? open_len_q : longest_q;

	always_comb begin
		unique case (id_q)
			STAT_LOST:    emit_value = snap_lost;
			STAT_INJ:     emit_value = injected_q;
			STAT_EVENTS:  emit_value = snap_events;
			STAT_LONGEST: emit_value = DATA_W'(snap_longest);
			STAT_BUCKET:  emit_value = bkt_ok_q ? hist_rdata : '0;
			default:      emit_value = cnt_rdata;
		endcase
	end

	always_comb begin
		state_d    = state_q;
		cnt_re     = 1'b0;
		cnt_raddr  = CNT_ATT;
		cnt_we     = 1'b0;
		cnt_waddr  = cnt_addr_q;
		cnt_wdata  = cnt_rdata + DATA_W'(1);
		hist_re    = 1'b0;
		hist_raddr = open_m1[HW-1:0];
		hist_we    = 1'b0;
		hist_waddr = hist_addr_q;
		hist_wdata = hist_rdata + DATA_W'(1);
		out_load   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cnt_we     = clr_in_cnt;
				cnt_waddr  = clr_q[CNT_AW-1:0];
				cnt_wdata  = '0;
				hist_we    = clr_in_hist;
				hist_waddr = clr_q[HW-1:0];
				hist_wdata = '0;
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					unique case (cmd)
						CMD_BLK_OK: begin
							cnt_re    = 1'b1;
							cnt_raddr = CNT_OK;
							state_d   = ST_CNT1;
						end
						CMD_BLK_FAIL: begin
							cnt_re    = 1'b1;
							cnt_raddr = CNT_FAIL;
							state_d   = ST_CNT1;
						end
						CMD_TMH: begin
							cnt_re    = 1'b1;
							cnt_raddr = CNT_TMH;
							state_d   = ST_CNT1;
						end
						CMD_TIMEOUT: begin
							cnt_re    = 1'b1;
							cnt_raddr = CNT_TIMEOUT;
							state_d   = ST_CNT1;
						end
						CMD_RX: begin
							cnt_re    = 1'b1;
							cnt_raddr = CNT_RX;
							state_d   = ST_CNT1;
						end
						CMD_CRC: begin
							cnt_re    = 1'b1;
							cnt_raddr = CNT_CRC;
							state_d   = ST_CNT1;
						end
						CMD_REC: begin
							cnt_re    = 1'b1;
							cnt_raddr = CNT_REC;
							state_d   = ST_CNT1;
						end
						CMD_PKTF: begin
							cnt_re    = 1'b1;
							cnt_raddr = CNT_PKTF;
							state_d   = ST_CNT1;
						end
						CMD_HOLES, CMD_FINAL: begin
							if (close_req && (open_len_q != '0)) begin
								hist_re = 1'b1;
								state_d = ST_HIST;
							end
						end
						CMD_SNAP: begin
							cnt_re    = 1'b1;
							cnt_raddr = CNT_ATT;
							state_d   = ST_EMIT;
						end
						CMD_BKT: begin
							hist_re    = bkt_ok;
							hist_raddr = bkt_m1[HW-1:0];
							state_d    = ST_EMIT;
						end
						default: begin
						end
					endcase
				end
			end
			ST_CNT1: begin
				cnt_we = 1'b1;
				if (two_q) begin
					// attempted count follows block ok or fail
					cnt_re    = 1'b1;
					cnt_raddr = CNT_ATT;
					state_d   = ST_CNT2;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_CNT2: begin
				cnt_we    = 1'b1;
				cnt_waddr = CNT_ATT;
				state_d   = ST_IDLE;
			end
			ST_HIST: begin
				hist_we = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SNAP_RD: begin
				cnt_re    = id_is_cnt;
				cnt_raddr = id_cnt_addr;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = id_last ? ST_IDLE : ST_SNAP_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q           <= '0;
			injected_q      <= '0;
			open_len_q      <= '0;
			closed_events_q <= '0;
			closed_lost_q   <= '0;
			longest_q       <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CLR_W'(1);
			end
			if (psel && penable && pwrite && (paddr == ADDR_INJECTED)) begin
				injected_q <= pwdata;
			end
			if (in_take && (cmd == CMD_HOLES) && (in_item.hole_total != 16'd0)) begin
				open_len_q <= hole_sat;
			end
			if (state_q == ST_HIST) begin
				closed_events_q <= snap_events;
				closed_lost_q   <= snap_lost;
				longest_q       <= snap_longest;
				open_len_q      <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cnt_addr_q  <= cnt_raddr;
			hist_addr_q <= hist_raddr;
			two_q       <= (cmd == CMD_BLK_OK) || (cmd == CMD_BLK_FAIL);
			bkt_ok_q    <= bkt_ok;
			id_q        <= (cmd == CMD_BKT) ? STAT_BUCKET : STAT_ATT;
		end else if (out_load && !id_last) begin
			id_q <= id_q + 4'd1;
		end
		if (out_load) begin
			out_item_q.stat_id     <= id_q;
			out_item_q.stat_value  <= emit_value;
			out_item_q.last_of_run <= id_last;
		end
	end

	lebh_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CNT_DEPTH)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.re   (cnt_re),
		.raddr(cnt_raddr),
		.rdata(cnt_rdata)
	);

	lebh_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_BURST)
	) u_hist_ram (
		.clk  (clk),
		.we   (hist_we),
		.waddr(hist_waddr),
		.wdata(hist_wdata),
		.re   (hist_re),
		.raddr(hist_raddr),
		.rdata(hist_rdata)
	);

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr == ADDR_INJECTED) ? injected_q : '0;

endmodule
`default_nettype wire

// ===== rtl/lebh_checker.sv =====
// port-level checks for the link event and burst histogram statistics block
`timescale 1ns / 1ps
`default_nettype none
module lebh_checker
	import lebh_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire in_item_t           in_item,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire out_item_t          out_item
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// only the longest-burst and bucket results close a run
	a_last_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.last_of_run ==
			((out_item.stat_id == STAT_LONGEST) || (out_item.stat_id == STAT_BUCKET))))
		else $error("last_of_run on wrong statistic");

	// no new item while a snapshot run is still being delivered
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.last_of_run |-> in_stall)
		else $error("input taken in the middle of a snapshot");

	// a snapshot or bucket read keeps the input stalled in the next cycle
	a_read_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall &&
		((in_item.command == CMD_SNAP) || (in_item.command == CMD_BKT)) |=> in_stall)
		else $error("input not stalled after a read command");

endmodule

bind link_event_and_burst_histogram_stats_top lebh_checker u_lebh_checker (.*);
`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the link event and burst histogram statistics block
`timescale 1ns / 1ps
module testbench;
	import lebh_pkg::*;

	localparam int MAX_BURST   = 256;
	localparam int STUCK_LIMIT = 4000;
	localparam int PHASE_ITEMS = 100;
	localparam int SETTLE      = 8;

	localparam logic [3:0] CMD_SPARE_LO = 4'd12;
	localparam logic [3:0] CMD_SPARE_HI = 4'd15;

	typedef enum logic [3:0] {
		SID_ATT, SID_OK, SID_FAIL, SID_TMH, SID_TIMEOUT, SID_RX, SID_CRC,
		SID_LOST, SID_INJ, SID_REC, SID_PKTF, SID_EVENTS, SID_LONGEST, SID_BUCKET
	} stat_id_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	in_item_t            in_item   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	out_item_t           out_item;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [PADDR_W-1:0]  paddr     = '0;
	logic [DATA_W-1:0]   pwdata    = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	in_item_t  events_to_send[$];
	out_item_t stats_due[$];
	out_item_t oldest_due;
	int        idle_pct     = 0;
	int        stall_pct    = 0;
	int        errors       = 0;
	int        stuck_cycles = 0;

	// shadow copy of the counters, histogram and burst tracking
	logic [63:0] inj_shadow = '0;
	logic [63:0] cnt_shadow [CNT_DEPTH] = '{default: '0};
	logic [63:0] hist_shadow [MAX_BURST] = '{default: '0};
	logic [8:0]  open_len       = '0;
	logic [63:0] bursts_closed  = '0;
	logic [63:0] symbols_closed = '0;
	logic [8:0]  longest_closed = '0;

	link_event_and_burst_histogram_stats_top #(.MAX_BURST(MAX_BURST)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void queue_stat(stat_id_t id, logic [63:0] value, logic last);
		out_item_t r;
		r.stat_id     = id;
		r.stat_value  = value;
		r.last_of_run = last;
		stats_due.push_back(r);
	endfunction

	function automatic void close_burst();
		if (open_len != 9'd0) begin
			hist_shadow[open_len - 9'd1] += 64'd1;
			bursts_closed  += 64'd1;
			symbols_closed += 64'(open_len);
			if (open_len > longest_closed)
				longest_closed = open_len;
			open_len = 9'd0;
		end
	endfunction

	function automatic void tally_event(in_item_t it);
		logic [16:0] grown;
		logic [63:0] events_now;
		logic [63:0] lost_now;
		logic [8:0]  longest_now;
		case (it.command)
			CMD_BLK_OK: begin
				cnt_shadow[CNT_ATT] += 64'd1;
				cnt_shadow[CNT_OK]  += 64'd1;
			end
			CMD_BLK_FAIL: begin
				cnt_shadow[CNT_ATT]  += 64'd1;
				cnt_shadow[CNT_FAIL] += 64'd1;
			end
			CMD_TMH:     cnt_shadow[CNT_TMH]     += 64'd1;
			CMD_TIMEOUT: cnt_shadow[CNT_TIMEOUT] += 64'd1;
			CMD_RX:      cnt_shadow[CNT_RX]      += 64'd1;
			CMD_CRC:     cnt_shadow[CNT_CRC]     += 64'd1;
			CMD_REC:     cnt_shadow[CNT_REC]     += 64'd1;
			CMD_PKTF:    cnt_shadow[CNT_PKTF]    += 64'd1;
			CMD_HOLES: begin
				if (it.hole_total != 16'd0) begin
					grown    = 17'(open_len) + 17'(it.hole_total);
					open_len = (grown > MAX_BURST) ? 9'(MAX_BURST) : grown[8:0];
				end else begin
					close_burst();
				end
			end
			CMD_FINAL: close_burst();
			CMD_SNAP: begin
				events_now  = bursts_closed;
				lost_now    = symbols_closed;
				longest_now = longest_closed;
				// the open burst shows up in the snapshot without being closed
				if (open_len != 9'd0) begin
					events_now += 64'd1;
					lost_now   += 64'(open_len);
					if (open_len > longest_now)
						longest_now = open_len;
				end
				queue_stat(SID_ATT,     cnt_shadow[CNT_ATT],     1'b0);
				queue_stat(SID_OK,      cnt_shadow[CNT_OK],      1'b0);
				queue_stat(SID_FAIL,    cnt_shadow[CNT_FAIL],    1'b0);
				queue_stat(SID_TMH,     cnt_shadow[CNT_TMH],     1'b0);
				queue_stat(SID_TIMEOUT, cnt_shadow[CNT_TIMEOUT], 1'b0);
				queue_stat(SID_RX,      cnt_shadow[CNT_RX],      1'b0);
				queue_stat(SID_CRC,     cnt_shadow[CNT_CRC],     1'b0);
				queue_stat(SID_LOST,    lost_now,                1'b0);
				queue_stat(SID_INJ,     inj_shadow,              1'b0);
				queue_stat(SID_REC,     cnt_shadow[CNT_REC],     1'b0);
				queue_stat(SID_PKTF,    cnt_shadow[CNT_PKTF],    1'b0);
				queue_stat(SID_EVENTS,  events_now,              1'b0);
				queue_stat(SID_LONGEST, 64'(longest_now),        1'b1);
			end
			CMD_BKT: begin
				if (it.bucket_number >= 9'd1 && it.bucket_number <= MAX_BURST)
					queue_stat(SID_BUCKET, hist_shadow[it.bucket_number - 9'd1], 1'b1);
				else
					queue_stat(SID_BUCKET, 64'd0, 1'b1);
			end
			default: ;
		endcase
	endfunction

	function automatic in_item_t make_item(logic [3:0] cmd, logic [15:0] holes,
			logic [8:0] bucket);
		in_item_t it;
		it.command       = cmd;
		it.hole_total    = holes;
		it.bucket_number = bucket;
		return it;
	endfunction

	// mostly short bursts so that low buckets fill up and get read back
	function automatic in_item_t random_event();
		in_item_t it;
		int       pick;
		pick             = $urandom_range(99);
		it.hole_total    = 16'($urandom);
		it.bucket_number = 9'($urandom);
		if (pick < 40) begin
			it.command = 4'($urandom_range(CMD_PKTF, CMD_BLK_OK));
		end else if (pick < 66) begin
			it.command = CMD_HOLES;
			if ($urandom_range(19) == 0)
				it.hole_total = 16'($urandom_range(65535, 1));
			else
				it.hole_total = 16'($urandom_range(8, 1));
		end else if (pick < 76) begin
			it.command    = CMD_HOLES;
			it.hole_total = '0;
		end else if (pick < 81) begin
			it.command = CMD_FINAL;
		end else if (pick < 89) begin
			it.command = CMD_BKT;
			pick       = $urandom_range(9);
			if (pick < 7)
				it.bucket_number = 9'($urandom_range(12, 1));
			else if (pick == 7)
				it.bucket_number = 9'(MAX_BURST);
		end else if (pick < 95) begin
			it.command = CMD_SNAP;
		end else begin
			it.command = 4'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
		end
		return it;
	endfunction

	task automatic write_injected(input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_INJECTED;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		inj_shadow  = value;
		// register reads back what was written
		@(posedge clk);
		if (prdata !== value) begin
			$display("%0t: prdata expected %h actual %h", $time, value, prdata);
			errors++;
		end
	endtask

	task automatic wait_idle();
		while (events_to_send.size() != 0 || in_valid || stats_due.size() != 0)
			@(posedge clk);
		// a burst close or counter update may still be in flight with nothing owed
		repeat (SETTLE) @(posedge clk);
	endtask

	// item driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tally_event(in_item);
			if (!in_valid || !in_stall) begin
				if (events_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
					in_item  <= events_to_send.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (stats_due.size() == 0) begin
					$display("%0t: unexpected result id %0d value %h last %b", $time,
						out_item.stat_id, out_item.stat_value, out_item.last_of_run);
					errors++;
				end else begin
					oldest_due = stats_due.pop_front();
					if (out_item.stat_id !== oldest_due.stat_id) begin
						$display("%0t: stat_id expected %0d actual %0d", $time,
							oldest_due.stat_id, out_item.stat_id);
						errors++;
					end
					if (out_item.stat_value !== oldest_due.stat_value) begin
						$display("%0t: stat_value (id %0d) expected %h actual %h", $time,
							oldest_due.stat_id, oldest_due.stat_value, out_item.stat_value);
						errors++;
					end
					if (out_item.last_of_run !== oldest_due.last_of_run) begin
						$display("%0t: last_of_run (id %0d) expected %b actual %b", $time,
							oldest_due.stat_id, oldest_due.last_of_run, out_item.last_of_run);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		while (stuck_cycles < STUCK_LIMIT)
			@(posedge clk);
		$display("[link_event_and_burst_histogram_stats_top] ERROR");
		$finish;
	end

	initial begin
		int       phase;
		int       count;
		in_item_t it;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset values, every event kind, saturation and close corners
		events_to_send.push_back(make_item(CMD_SNAP, '0, '0));
		events_to_send.push_back(make_item(CMD_BKT, '0, 9'd0));
		events_to_send.push_back(make_item(CMD_BKT, '1, 9'd511));
		for (int c = CMD_BLK_OK; c <= CMD_PKTF; c++)
			events_to_send.push_back(make_item(4'(c), '0, '0));
		events_to_send.push_back(make_item(CMD_HOLES, 16'd0, '0));
		events_to_send.push_back(make_item(CMD_FINAL, '0, '0));
		events_to_send.push_back(make_item(CMD_HOLES, 16'hFFFF, '0));
		events_to_send.push_back(make_item(CMD_HOLES, 16'd1, '0));
		events_to_send.push_back(make_item(CMD_SNAP, '0, '0));
		events_to_send.push_back(make_item(CMD_HOLES, 16'd0, '1));
		events_to_send.push_back(make_item(CMD_BKT, '0, 9'(MAX_BURST)));
		events_to_send.push_back(make_item(CMD_HOLES, 16'd1, '0));
		events_to_send.push_back(make_item(CMD_HOLES, 16'd2, '0));
		events_to_send.push_back(make_item(CMD_FINAL, '0, '0));
		events_to_send.push_back(make_item(CMD_BKT, '0, 9'd3));
		events_to_send.push_back(make_item(CMD_SPARE_LO, '1, '1));
		events_to_send.push_back(make_item(CMD_SPARE_HI, '1, '1));
		events_to_send.push_back(make_item(CMD_SNAP, '0, '0));
		wait_idle();

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					write_injected('1);
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					write_injected({$urandom, $urandom});
					idle_pct  = 84;
					stall_pct = 0;
				end
				2: begin
					write_injected(64'd1);
					idle_pct  = 0;
					stall_pct = 84;
				end
				default: begin
					write_injected(64'h8000_0000_0000_0000);
					idle_pct  = 24;
					stall_pct = 24;
				end
			endcase
			count = 0;
			while (count < PHASE_ITEMS) begin
				it = random_event();
				events_to_send.push_back(it);
				if (it.command <= CMD_BKT)
					count++;
			end
			events_to_send.push_back(make_item(CMD_SNAP, '0, '0));
			wait_idle();
		end

		write_injected('0);
		idle_pct  = 0;
		stall_pct = 0;
		events_to_send.push_back(make_item(CMD_SNAP, '0, '0));
		wait_idle();

		if (errors == 0)
			$display("[link_event_and_burst_histogram_stats_top] OK");
		else
			$display("[link_event_and_burst_histogram_stats_top] ERROR");
		$finish;
	end

endmodule
